// ===== hw/rtl/jppf_pkg.sv =====
// Shared types and character constants for the JSON pretty-print formatter.
package jppf_pkg;

  localparam int LEVEL_W   = 7;
  localparam int MAX_LEVEL = 63;
  localparam int SPACES_W  = 10;
  localparam int INDENT_W  = 4;

  localparam logic [INDENT_W-1:0] INDENT_RESET = 4'd2;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  typedef logic signed [LEVEL_W-1:0] level_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       start_of_text;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic                newline_before;
    logic [SPACES_W-1:0] spaces_before;
    logic [7:0]          text_byte;
    logic                space_after;
    logic                last_chunk;
  } out_item_t;

endpackage

// ===== hw/rtl/json_pretty_print_formatter.sv =====
// JSON pretty-print formatter: one output chunk per input byte.
//
// Input channel (in_valid/in_ready/in_data) takes one byte of compact JSON
// text per word, with start_of_text and end_of_text flags. Output channel
// (out_valid/out_ready/out_data) gives one chunk per byte: an optional line
// feed, a count of indent spaces, the byte, and an optional space after it.
// The configuration channel (cfg_valid/cfg_ready/cfg_data) writes the indent
// width and is always ready. The user must write it only while the block is
// idle; the block itself does not enforce this.
//
// Each byte passes one input register, then the formatting logic and the
// state update into the output register. Throughput is one byte per cycle
// while the receiver does not stall; the nesting level and marks update with
// the output register, so each byte sees the state left by the last.
// When the receiver stalls the output register holds, the input register
// fills, and in_ready drops only once both are occupied.
// Synchronous reset empties both registers, clears level, marks and previous
// byte to zero, and sets the indent width to 2.
module json_pretty_print_formatter (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  jppf_pkg::in_item_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output jppf_pkg::out_item_t          out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [jppf_pkg::INDENT_W-1:0] cfg_data
);

  logic [jppf_pkg::INDENT_W-1:0] indent_width;

  logic               s1_valid;
  jppf_pkg::in_item_t s1_item;
  logic               s1_advance;

  jppf_pkg::level_t nesting_level, nesting_level_next;
  logic             line_start_pending, line_start_pending_next;
  logic             inside_string, inside_string_next;
  logic             after_backslash, after_backslash_next;
  logic [7:0]       previous_byte;

  jppf_pkg::out_item_t res_next;

  // Working copies of the state after an optional start-of-text clear.
  jppf_pkg::level_t lvl_cur;
  logic             lsp_cur, str_cur, esc_cur;
  logic [7:0]       prev_cur;
  jppf_pkg::level_t lvl_ind;
  logic [5:0]       lvl_pos;
  logic [jppf_pkg::SPACES_W-1:0] indent;
  logic             is_close;
  logic             open_prev;

  assign cfg_ready  = 1'b1;
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      indent_width <= jppf_pkg::INDENT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      indent_width <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  always_comb begin
    if (s1_item.start_of_text) begin
      lvl_cur  = '0;
      lsp_cur  = 1'b0;
      str_cur  = 1'b0;
      esc_cur  = 1'b0;
      prev_cur = 8'h00;
    end else begin
      lvl_cur  = nesting_level;
      lsp_cur  = line_start_pending;
      str_cur  = inside_string;
      esc_cur  = after_backslash;
      prev_cur = previous_byte;
    end

    is_close  = (s1_item.in_byte == jppf_pkg::CH_RBRACE) ||
                (s1_item.in_byte == jppf_pkg::CH_RBRACK);
    open_prev = (prev_cur == jppf_pkg::CH_LBRACE) || (prev_cur == jppf_pkg::CH_LBRACK);

    // Closing brackets outside strings indent at the lowered level.
    if (is_close && !str_cur && lvl_cur > -jppf_pkg::level_t'(jppf_pkg::MAX_LEVEL)) begin
      lvl_ind = lvl_cur - jppf_pkg::level_t'(1);
    end else begin
      lvl_ind = lvl_cur;
    end
    lvl_pos = (lvl_ind > 0) ? lvl_ind[5:0] : 6'd0;
    indent  = {4'd0, lvl_pos} * {6'd0, indent_width};

    nesting_level_next      = lvl_cur;
    line_start_pending_next = lsp_cur;
    inside_string_next      = str_cur;
    after_backslash_next    = 1'b0;

    res_next.newline_before = 1'b0;
    res_next.spaces_before  = '0;
    res_next.text_byte      = s1_item.in_byte;
    res_next.space_after    = 1'b0;
    res_next.last_chunk     = s1_item.end_of_text;

    case (s1_item.in_byte)
      jppf_pkg::CH_BSLASH: begin
        after_backslash_next = !esc_cur && str_cur;
      end
      jppf_pkg::CH_COLON: begin
        res_next.space_after = !str_cur;
      end
      jppf_pkg::CH_QUOTE: begin
        if (lsp_cur) begin
          res_next.newline_before = 1'b1;
          res_next.spaces_before  = indent;
          line_start_pending_next = 1'b0;
        end
        if (!esc_cur) begin
          inside_string_next = !str_cur;
        end
      end
      jppf_pkg::CH_LBRACE, jppf_pkg::CH_LBRACK: begin
        if (!str_cur) begin
          if (lvl_cur < jppf_pkg::level_t'(jppf_pkg::MAX_LEVEL)) begin
            nesting_level_next = lvl_cur + jppf_pkg::level_t'(1);
          end
          line_start_pending_next = 1'b1;
        end
      end
      jppf_pkg::CH_RBRACE, jppf_pkg::CH_RBRACK: begin
        if (!str_cur) begin
          res_next.newline_before = !open_prev;
          nesting_level_next      = lvl_ind;
          if (!lsp_cur) begin
            res_next.spaces_before = indent;
          end
        end
      end
      jppf_pkg::CH_COMMA: begin
        if (!str_cur) begin
          line_start_pending_next = 1'b1;
        end
      end
      default: begin
        if (lsp_cur) begin
          res_next.newline_before = 1'b1;
          res_next.spaces_before  = indent;
          line_start_pending_next = 1'b0;
        end
      end
    endcase
  end

  // Advance state and output register together
  always_ff @(posedge clk) begin
    if (rst) begin
      nesting_level      <= '0;
      line_start_pending <= 1'b0;
      inside_string      <= 1'b0;
      after_backslash    <= 1'b0;
      previous_byte      <= 8'h00;
    end else if (s1_advance) begin
      nesting_level      <= nesting_level_next;
      line_start_pending <= line_start_pending_next;
      inside_string      <= inside_string_next;
      after_backslash    <= after_backslash_next;
      previous_byte      <= s1_item.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_data <= res_next;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    (nesting_level <= jppf_pkg::level_t'(jppf_pkg::MAX_LEVEL)) &&
    (nesting_level >= -jppf_pkg::level_t'(jppf_pkg::MAX_LEVEL)))
    else $error("nesting level out of range");

  a_escape_in_string: assert property (@(posedge clk) disable iff (rst)
    after_backslash |-> inside_string)
    else $error("escape mark set outside a string");

  a_space_after_colon: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.space_after) |-> (out_data.text_byte == jppf_pkg::CH_COLON))
    else $error("trailing space on a byte other than a colon");

  a_indent_source: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.spaces_before != '0) |->
    (out_data.newline_before || out_data.text_byte == jppf_pkg::CH_RBRACE ||
     out_data.text_byte == jppf_pkg::CH_RBRACK))
    else $error("indent without line feed on a non-closing byte");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && out_valid && !out_ready) |=> s1_valid)
    else $error("input register dropped a word while output stalled");

endmodule

// ===== tb/json_pretty_print_formatter_test.sv =====
// Self-checking testbench for the JSON pretty-print formatter.
module json_pretty_print_formatter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int MAX_PRINTS   = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                          in_valid = 1'b0;
  logic                          in_ready;
  jppf_pkg::in_item_t            in_data = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  jppf_pkg::out_item_t           out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [jppf_pkg::INDENT_W-1:0] cfg_data = '0;

  json_pretty_print_formatter dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  jppf_pkg::in_item_t  pending_bytes[$];
  jppf_pkg::out_item_t expected_chunks[$];
  logic [7:0] doc_bytes[$];
  int pushed_count;
  int mismatch_count;
  int chunk_count;
  int cycle_count;
  logic word_taken;

  // Formatter state as the block should hold it
  jppf_pkg::level_t              fmt_level;
  logic                          line_pend;
  logic                          in_str;
  logic                          esc_mark;
  logic [7:0]                    prev_char;
  logic [jppf_pkg::INDENT_W-1:0] indent_width;

  function automatic logic [jppf_pkg::SPACES_W-1:0] indent_now();
    int n;
    if (fmt_level <= 0) return '0;
    n = int'(fmt_level) * int'(indent_width);
    return (n > 1023) ? 10'd1023 : n[jppf_pkg::SPACES_W-1:0];
  endfunction

  function automatic jppf_pkg::out_item_t format_char(jppf_pkg::in_item_t w);
    jppf_pkg::out_item_t c;
    logic [7:0] ch;
    ch = w.in_byte;
    c = '0;
    c.text_byte = ch;
    c.last_chunk = w.end_of_text;
    if (w.start_of_text) begin
      fmt_level = '0;
      line_pend = 1'b0;
      in_str = 1'b0;
      esc_mark = 1'b0;
      prev_char = '0;
    end
    case (ch)
      jppf_pkg::CH_BSLASH: begin
        if (esc_mark) esc_mark = 1'b0;
        else if (in_str) esc_mark = 1'b1;
      end
      jppf_pkg::CH_COLON: begin
        if (!in_str) c.space_after = 1'b1;
        esc_mark = 1'b0;
      end
      jppf_pkg::CH_QUOTE: begin
        if (line_pend) begin
          c.newline_before = 1'b1;
          c.spaces_before = indent_now();
          line_pend = 1'b0;
        end
        if (!esc_mark) in_str = ~in_str;
        esc_mark = 1'b0;
      end
      jppf_pkg::CH_LBRACE, jppf_pkg::CH_LBRACK: begin
        if (!in_str) begin
          if (fmt_level < jppf_pkg::level_t'(jppf_pkg::MAX_LEVEL))
            fmt_level = fmt_level + jppf_pkg::level_t'(1);
          line_pend = 1'b1;
        end
        esc_mark = 1'b0;
      end
      jppf_pkg::CH_RBRACE, jppf_pkg::CH_RBRACK: begin
        if (!in_str) begin
          if (prev_char != jppf_pkg::CH_LBRACK && prev_char != jppf_pkg::CH_LBRACE)
            c.newline_before = 1'b1;
          if (fmt_level > -jppf_pkg::level_t'(jppf_pkg::MAX_LEVEL))
            fmt_level = fmt_level - jppf_pkg::level_t'(1);
          if (!line_pend) c.spaces_before = indent_now();
        end
        esc_mark = 1'b0;
      end
      jppf_pkg::CH_COMMA: begin
        if (!in_str) line_pend = 1'b1;
        esc_mark = 1'b0;
      end
      default: begin
        if (line_pend) begin
          c.newline_before = 1'b1;
          c.spaces_before = indent_now();
          line_pend = 1'b0;
        end
        esc_mark = 1'b0;
      end
    endcase
    prev_char = ch;
    return c;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (mismatch_count < MAX_PRINTS)
      $display("chunk %0d: %s got %0d want %0d", chunk_count, field, got, want);
    mismatch_count++;
  endtask

  // Sample both channels and the register port on the rising edge
  always @(posedge clk) begin
    jppf_pkg::out_item_t want;
    cycle_count++;
    word_taken = 1'b0;
    if (rst) begin
      fmt_level = '0;
      line_pend = 1'b0;
      in_str = 1'b0;
      esc_mark = 1'b0;
      prev_char = '0;
      indent_width = jppf_pkg::INDENT_RESET;
    end else begin
      if (in_valid && in_ready) begin
        expected_chunks = {expected_chunks, format_char(in_data)};
        word_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (expected_chunks.size() == 0) begin
          report_mismatch("unexpected word", int'(out_data), 0);
        end else begin
          want = expected_chunks.pop_front();
          if (out_data.newline_before != want.newline_before)
            report_mismatch("newline_before", int'(out_data.newline_before),
                            int'(want.newline_before));
          if (out_data.spaces_before != want.spaces_before)
            report_mismatch("spaces_before", int'(out_data.spaces_before),
                            int'(want.spaces_before));
          if (out_data.text_byte != want.text_byte)
            report_mismatch("text_byte", int'(out_data.text_byte), int'(want.text_byte));
          if (out_data.space_after != want.space_after)
            report_mismatch("space_after", int'(out_data.space_after),
                            int'(want.space_after));
          if (out_data.last_chunk != want.last_chunk)
            report_mismatch("last_chunk", int'(out_data.last_chunk), int'(want.last_chunk));
        end
        chunk_count++;
      end
      if (cfg_valid && cfg_ready) indent_width = cfg_data;
    end
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("status: fail");
      $finish;
    end
  end

  // Sender: bursts of words with random gaps
  int burst_left = 1;
  int gap_left = 0;
  int gap_pick;
  logic drv_valid;
  jppf_pkg::in_item_t drv_word;

  always @(negedge clk) begin
    if (!rst) begin
      drv_valid = in_valid;
      drv_word = in_data;
      if (in_valid && word_taken) drv_valid = 1'b0;
      if (!drv_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_bytes.size() > 0) begin
          drv_word = pending_bytes.pop_front();
          drv_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_pick = $urandom_range(0, 9);
            gap_left = (gap_pick < 4) ? 0 :
                       (gap_pick < 8) ? $urandom_range(1, 3) : $urandom_range(4, 12);
          end
        end
      end
      in_valid <= drv_valid;
      in_data <= drv_word;
    end
  end

  // Receiver: stall pattern switches with bits 8:7 of the rx_cycle counter
  logic [15:0] rx_cycle = '0;
  int stall_left = 0;
  logic rx_ready;

  always @(negedge clk) begin
    rx_cycle++;
    if (stall_left > 0) begin
      stall_left--;
      rx_ready = 1'b0;
    end else begin
      case (rx_cycle[8:7])
        2'd0: rx_ready = 1'b1;
        2'd1: rx_ready = ($urandom_range(0, 3) != 0);
        2'd2: rx_ready = 1'($urandom_range(0, 1));
        default: begin
          rx_ready = 1'b1;
          if ($urandom_range(0, 19) == 0) begin
            stall_left = $urandom_range(4, 24);
            rx_ready = 1'b0;
          end
        end
      endcase
    end
    out_ready <= rx_ready;
  end

  task automatic push_char(logic [7:0] ch, logic sot, logic eot);
    jppf_pkg::in_item_t w;
    w.in_byte = ch;
    w.start_of_text = sot;
    w.end_of_text = eot;
    pending_bytes = {pending_bytes, w};
    pushed_count++;
  endtask

  task automatic push_text(string s, logic sot, logic eot);
    for (int i = 0; i < s.len(); i++)
      push_char(s[i], sot && (i == 0), eot && (i == s.len() - 1));
  endtask

  task automatic put_byte(logic [7:0] b);
    doc_bytes = {doc_bytes, b};
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic gen_string();
    int n;
    int pick;
    put_byte(jppf_pkg::CH_QUOTE);
    n = $urandom_range(0, 6);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4) begin
        put_byte(8'($urandom_range(8'h61, 8'h7A)));
      end else if (pick < 6) begin
        add_text("{}[],:");
        repeat ($urandom_range(0, 5)) void'(doc_bytes.pop_back());
      end else if (pick < 8) begin
        put_byte(jppf_pkg::CH_BSLASH);
        case ($urandom_range(0, 2))
          0: put_byte(jppf_pkg::CH_QUOTE);
          1: put_byte(jppf_pkg::CH_BSLASH);
          default: put_byte("n");
        endcase
      end else begin
        put_byte(8'($urandom_range(8'h80, 8'hFF)));
      end
    end
    put_byte(jppf_pkg::CH_QUOTE);
  endtask

  task automatic gen_value(int depth);
    int kind;
    int n;
    string digits;
    digits = "-0123456789.eE+";
    kind = (depth <= 0) ? $urandom_range(2, 4) : $urandom_range(0, 5);
    case (kind)
      0, 5: begin
        put_byte(jppf_pkg::CH_LBRACE);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_byte(jppf_pkg::CH_COMMA);
          gen_string();
          put_byte(jppf_pkg::CH_COLON);
          gen_value(depth - 1);
        end
        put_byte(jppf_pkg::CH_RBRACE);
      end
      1: begin
        put_byte(jppf_pkg::CH_LBRACK);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
          if (i > 0) put_byte(jppf_pkg::CH_COMMA);
          gen_value(depth - 1);
        end
        put_byte(jppf_pkg::CH_RBRACK);
      end
      2: gen_string();
      3: begin
        n = $urandom_range(1, 4);
        for (int i = 0; i < n; i++) put_byte(digits[$urandom_range(0, 14)]);
      end
      default: begin
        case ($urandom_range(0, 2))
          0: add_text("true");
          1: add_text("false");
          default: add_text("null");
        endcase
      end
    endcase
  endtask

  // One text of random content; a broken one loses its tail or a byte
  task automatic gen_doc(logic broken);
    int cut;
    doc_bytes.delete();
    gen_value($urandom_range(1, 4));
    if (broken && doc_bytes.size() > 1) begin
      cut = $urandom_range(0, doc_bytes.size() - 1);
      if ($urandom_range(0, 1)) begin
        while (doc_bytes.size() > cut + 1) void'(doc_bytes.pop_back());
      end else begin
        doc_bytes.delete(cut);
      end
    end
    for (int i = 0; i < doc_bytes.size(); i++)
      push_char(doc_bytes[i], (i == 0) && (!broken || $urandom_range(0, 1)),
                i == doc_bytes.size() - 1);
  endtask

  task automatic fill_random(int n);
    int goal;
    int pick;
    logic [7:0] ch;
    goal = pushed_count + n;
    while (pushed_count < goal) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        gen_doc(1'b0);
      end else if (pick < 8) begin
        gen_doc(1'b1);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 7))
              0: ch = jppf_pkg::CH_BSLASH;
              1: ch = jppf_pkg::CH_COLON;
              2: ch = jppf_pkg::CH_QUOTE;
              3: ch = jppf_pkg::CH_LBRACE;
              4: ch = jppf_pkg::CH_LBRACK;
              5: ch = jppf_pkg::CH_RBRACE;
              6: ch = jppf_pkg::CH_RBRACK;
              default: ch = jppf_pkg::CH_COMMA;
            endcase
          end else begin
            ch = 8'($urandom_range(0, 255));
          end
          push_char(ch, $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
        end
      end
    end
  endtask

  // Drive the level to its top, then well below zero to its floor
  task automatic deep_run();
    push_char(jppf_pkg::CH_LBRACK, 1'b1, 1'b0);
    repeat (69) push_char(jppf_pkg::CH_LBRACK, 1'b0, 1'b0);
    push_text("\"a\"", 1'b0, 1'b0);
    repeat (139) push_char(jppf_pkg::CH_RBRACK, 1'b0, 1'b0);
    push_char(jppf_pkg::CH_RBRACE, 1'b0, 1'b1);
  endtask

  // Check on the rising edge, where the sender's outputs are settled
  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || expected_chunks.size() != 0)
      @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_indent(logic [jppf_pkg::INDENT_W-1:0] w);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  logic [jppf_pkg::INDENT_W-1:0] phase_width[6];

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: closer first, empty object, brackets and escapes in a string,
    // colon and backslash outside, byte extremes, closer after a comma
    push_text("]}", 1'b1, 1'b0);
    push_text("{}[\"{],:\\\"\\\\\"", 1'b1, 1'b0);
    push_text(":\\[", 1'b0, 1'b0);
    push_char(8'h00, 1'b0, 1'b0);
    push_char(8'hFF, 1'b0, 1'b0);
    push_text(",]", 1'b0, 1'b1);
    wait_drained();

    phase_width = '{4'd15, 4'd0, 4'd1, 4'd7, 4'($urandom_range(2, 14)),
                    4'($urandom_range(2, 14))};
    for (int p = 0; p < 6; p++) begin
      write_indent(phase_width[p]);
      if (p == 0 || p == 3) deep_run();
      if (p == 2) begin
        // Hold off mid-phase until every chunk is back
        fill_random(70);
        wait_drained();
        fill_random(70);
      end else begin
        fill_random(140);
      end
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (mismatch_count == 0 && expected_chunks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
